### rtl/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg: brake conversion model constants and lookup tables
// Thresholds, build-up coefficients and the lambda-indexed tables for the limit
// speed and the deceleration bands. The tables are built when the design is
// elaborated, so the hardware only sees constant arrays.
// ----------------------------------------------------------------------------
`default_nettype none

package bcm_pkg;

	localparam logic [7:0]  LAM_LOW       = 8'd30;
	localparam logic [7:0]  LAM_HIGH      = 8'd250;
	localparam logic [7:0]  LAM_SB_CAP    = 8'd135;
	localparam logic [8:0]  SPEED_CAP     = 9'd200;
	localparam logic [11:0] LEN_CAP_PASS  = 12'd900;
	localparam logic [11:0] LEN_CAP_FRT   = 12'd1500;
	localparam logic [11:0] LEN_SPLIT     = 12'd900;
	localparam logic [11:0] LEN_FLOOR     = 12'd400;

	// Brake position codes
	localparam logic [1:0] POS_PASS_P  = 2'd0;
	localparam logic [1:0] POS_FRT_P   = 2'd1;
	localparam logic [1:0] POS_FRT_G   = 2'd2;

	// Time conversion: q = (us*pct + 195312) / 390625, done by reciprocal
	localparam logic [6:0]  PCT_BASIC   = 7'd100;
	localparam logic [6:0]  PCT_G       = 7'd116;
	localparam logic [6:0]  PCT_OTHER   = 7'd120;
	localparam logic [35:0] TIME_HALF   = 36'd195312;
	localparam logic [18:0] TIME_DIV    = 19'd390625;
	localparam logic [21:0] TIME_RECIP  = 22'd2814749;
	localparam logic [14:0] TIME_MAX    = 15'd32767;

	localparam int NSLOT = 6;

	localparam longint EXPO_Q16      = 64'sd28049;
	localparam longint VLIM_GAIN_Q16 = 64'sd1104282;
	localparam longint ACC_UNIT      = 64'sd100000000000;

	localparam logic [63:0] POW2_FRAC [16] = '{
		64'd23726566, 64'd19951585, 64'd18295684, 64'd17520007,
		64'd17144589, 64'd16959908, 64'd16868315, 64'd16822704,
		64'd16799944, 64'd16788576, 64'd16782895, 64'd16780055,
		64'd16778636, 64'd16777926, 64'd16777571, 64'd16777393
	};

	localparam longint BAND_COEF [5][4] = '{
		'{64'sd6630000000,  64'sd472000000, 64'sd6100000,  -64'sd63000},
		'{64'sd13000000000, 64'sd514000000, -64'sd454000,  64'sd27300},
		'{64'sd4790000000,  64'sd581000000, -64'sd676000,  64'sd5580},
		'{64'sd4800000000,  64'sd552000000, -64'sd385000,  64'sd3000},
		'{64'sd5590000000,  64'sd506000000, 64'sd166000,   64'sd323}
	};

	localparam logic [11:0] BAND_EDGE [4] = '{12'd1600, 12'd1920, 12'd2400, 12'd2880};

	typedef logic [255:0][11:0] vlim_tab_t;
	typedef logic [255:0][15:0] dec_tab_t;

	// Build-up time polynomial selection for one brake
	typedef struct packed {
		logic signed [11:0] a;
		logic [8:0]         b;
		logic [4:0]         c;
		logic [11:0]        len;
	} bcm_coef_t;

	// Breakpoint run of one train data entry, emergency slots first
	typedef struct packed {
		logic              app;
		logic [11:0][11:0] spd;
		logic [11:0][15:0] dec;
		logic [11:0]       mask;
	} bcm_rec_t;

	// Limit speed 16.85*lambda^0.428 in 1/16 km/h
	function automatic logic [11:0] knee_speed(input logic [63:0] lam);
		logic [63:0] e, x, frac, lg, y, ip, fp, r;
		e = '0;
		frac = '0;
		if (lam == '0) begin
			return '0;
		end
		for (int i = 0; i < 8; i++) begin
			if ((lam >> (i + 1)) != '0) begin
				e = 64'(i + 1);
			end
		end
		x = lam << (64'd24 - e);
		for (int i = 0; i < 16; i++) begin
			x = (x * x) >> 24;
			frac = frac << 1;
			if (x >= (64'd1 << 25)) begin
				x = x >> 1;
				frac = frac | 64'd1;
			end
		end
		lg = (e << 16) | frac;
		y = (lg * 64'(EXPO_Q16)) >> 16;
		ip = y >> 16;
		fp = y & 64'hFFFF;
		r = 64'd1 << 24;
		for (int i = 0; i < 16; i++) begin
			if (((fp >> (15 - i)) & 64'd1) != '0) begin
				r = (r * POW2_FRAC[i]) >> 24;
			end
		end
		r = r << (ip & 64'd7);
		r = (r * 64'(VLIM_GAIN_Q16) + (64'd1 << 35)) >> 36;
		return (r > 64'd4095) ? 12'd4095 : r[11:0];
	endfunction

	// Round half up to 1/4096 m/s2, clamp and saturate
	function automatic logic [15:0] to_decel(input longint s);
		longint q;
		if (s <= 0) begin
			return '0;
		end
		q = (s * 64'sd4096 + ACC_UNIT / 2) / ACC_UNIT;
		return (q > 64'sd65535) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic vlim_tab_t build_vlim();
		vlim_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = knee_speed(64'(i));
		end
		return t;
	endfunction

	// Table zero is the value at standstill, tables one to five the bands
	function automatic dec_tab_t build_dec(input int sel);
		dec_tab_t t;
		longint l;
		for (int i = 0; i < 256; i++) begin
			l = longint'(i);
			if (sel == 0) begin
				t[i] = to_decel(64'sd750000000 * l + 64'sd7600000000);
			end else begin
				t[i] = to_decel(BAND_COEF[sel-1][0] + l * (BAND_COEF[sel-1][1]
					+ l * (BAND_COEF[sel-1][2] + l * BAND_COEF[sel-1][3])));
			end
		end
		return t;
	endfunction

	localparam vlim_tab_t VLIM_TAB = build_vlim();
	localparam dec_tab_t DEC_TAB [6] = '{
		build_dec(0), build_dec(1), build_dec(2),
		build_dec(3), build_dec(4), build_dec(5)
	};

endpackage

`default_nettype wire

### rtl/brake_conversion_model.sv
// ----------------------------------------------------------------------------
// brake_conversion_model: ETCS style brake conversion model
// Checks whether the conversion model applies and emits the step-curve
// breakpoints of the emergency and service deceleration curves together with
// the four brake build-up times.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. It runs through a
// six-stage pipeline (table lookup, build-up polynomial, time scaling, and a
// reciprocal divide with correction) and then into the output sequencer, which
// sends one result per cycle on result_strobe: seven to twelve results for an
// applicable request, one result when the model does not apply. The receiver
// cannot stall; the run length of the sequencer sets the sustained rate, so an
// applicable request holds the sequencer for its seven to twelve results, and a new request
// is taken while the previous one is still in the pipeline or being sent.
`default_nettype none

module brake_conversion_model
	import bcm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  brake_percent,
	input  wire logic [1:0]  position_kind,
	input  wire logic [11:0] train_length_m,
	input  wire logic [8:0]  max_speed_kmh,
	output logic             result_strobe,
	output logic             applicable,
	output logic             curve_kind,
	output logic [11:0]      speed_from,
	output logic [15:0]      decel_value,
	output logic [14:0]      eb_time_basic,
	output logic [14:0]      eb_time_scaled,
	output logic [14:0]      sb_time_basic,
	output logic [14:0]      sb_time_scaled,
	output logic             last_item
);

	// ---------------- pipeline control ----------------
	logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	logic em_v_q;
	logic em_free;
	logic [11:0] em_mask_q;
	logic [11:0] em_rest;

	assign em_rest = em_mask_q & (em_mask_q - 12'd1);
	assign em_free = !em_v_q || (em_rest == '0);
	assign rdy6 = !v6_q || em_free;
	assign rdy5 = !v5_q || rdy6;
	assign rdy4 = !v4_q || rdy5;
	assign rdy3 = !v3_q || rdy4;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign busy = !rdy1;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			v6_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= start;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
			if (rdy5) v5_q <= v4_q;
			if (rdy6) v6_q <= v5_q;
		end
	end

	// ---------------- stage 1: check and select coefficients ----------------
	logic        app_c;
	logic [11:0] fl_c;
	logic        len_low_c;
	bcm_coef_t   eb_c, sb_c;

	assign fl_c = (train_length_m < LEN_FLOOR) ? LEN_FLOOR : train_length_m;
	assign len_low_c = (train_length_m <= LEN_SPLIT);
	assign app_c = (brake_percent >= LAM_LOW) && (brake_percent <= LAM_HIGH)
		&& (max_speed_kmh <= SPEED_CAP)
		&& (train_length_m < ((position_kind == POS_PASS_P) ? LEN_CAP_PASS : LEN_CAP_FRT));

	// Pick build-up polynomials by brake position and length
	always_comb begin
		case (position_kind)
			POS_PASS_P: begin
				eb_c = '{a: 12'sd230, b: 9'd0, c: 5'd17, len: fl_c};
				sb_c = '{a: 12'sd300, b: 9'd150, c: 5'd10, len: train_length_m};
			end
			POS_FRT_P: begin
				eb_c = len_low_c ? bcm_coef_t'{a: 12'sd230, b: 9'd0, c: 5'd17, len: fl_c}
					: bcm_coef_t'{a: -12'sd50, b: 9'd160, c: 5'd3, len: train_length_m};
				sb_c = len_low_c ? bcm_coef_t'{a: 12'sd300, b: 9'd277, c: 5'd0, len: train_length_m}
					: bcm_coef_t'{a: 12'sd1050, b: 9'd32, c: 5'd18, len: train_length_m};
			end
			default: begin
				eb_c = len_low_c ? bcm_coef_t'{a: 12'sd1200, b: 9'd0, c: 5'd5, len: train_length_m}
					: bcm_coef_t'{a: -12'sd40, b: 9'd160, c: 5'd3, len: train_length_m};
				sb_c = len_low_c ? bcm_coef_t'{a: 12'sd300, b: 9'd277, c: 5'd0, len: fl_c}
					: bcm_coef_t'{a: 12'sd1050, b: 9'd32, c: 5'd18, len: train_length_m};
			end
		endcase
	end

	logic [7:0] lam_s1, lams_s1;
	logic       app_s1;
	logic [6:0] pct_s1;
	bcm_coef_t  eb_s1, sb_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			lam_s1  <= brake_percent;
			lams_s1 <= (brake_percent > LAM_SB_CAP) ? LAM_SB_CAP : brake_percent;
			app_s1  <= app_c;
			pct_s1  <= (position_kind >= POS_FRT_G) ? PCT_G : PCT_OTHER;
			eb_s1   <= eb_c;
			sb_s1   <= sb_c;
		end
	end

	// ---------------- stage 2: table lookup, partial products ----------------
	logic [1:0][11:0]       vlim_s2;
	logic [1:0][5:0][15:0]  dec_s2;
	logic                   app_s2;
	logic [6:0]             pct_s2;
	logic signed [24:0]     a10k_s2 [2];
	logic [20:0]            blen_s2 [2];
	logic [23:0]            lsq_s2 [2];
	logic [4:0]             c_s2 [2];

	always_ff @(posedge clk) begin
		if (rdy2) begin
			vlim_s2[0] <= VLIM_TAB[lam_s1];
			vlim_s2[1] <= VLIM_TAB[lams_s1];
			for (int k = 0; k < NSLOT; k++) begin
				dec_s2[0][k] <= DEC_TAB[k][lam_s1];
				dec_s2[1][k] <= DEC_TAB[k][lams_s1];
			end
			app_s2     <= app_s1;
			pct_s2     <= pct_s1;
			a10k_s2[0] <= 25'(eb_s1.a) * 25'sd10000;
			a10k_s2[1] <= 25'(sb_s1.a) * 25'sd10000;
			blen_s2[0] <= 21'(eb_s1.b) * 21'(eb_s1.len);
			blen_s2[1] <= 21'(sb_s1.b) * 21'(sb_s1.len);
			lsq_s2[0]  <= 24'(eb_s1.len) * 24'(eb_s1.len);
			lsq_s2[1]  <= 24'(sb_s1.len) * 24'(sb_s1.len);
			c_s2[0]    <= eb_s1.c;
			c_s2[1]    <= sb_s1.c;
		end
	end

	// ---------------- stage 3: breakpoints and build-up time in us ----------------
	bcm_rec_t rec_c;

	// Lay out six slots per curve and mark those that exist
	always_comb begin
		rec_c = '0;
		rec_c.app = app_s2;
		for (int cv = 0; cv < 2; cv++) begin
			for (int k = 0; k < NSLOT; k++) begin
				rec_c.dec[cv*NSLOT+k] = dec_s2[cv][k];
			end
			rec_c.spd[cv*NSLOT]    = '0;
			rec_c.mask[cv*NSLOT]   = 1'b1;
			rec_c.spd[cv*NSLOT+1]  = vlim_s2[cv];
			rec_c.mask[cv*NSLOT+1] = (vlim_s2[cv] < BAND_EDGE[0]);
			for (int n = 1; n <= 4; n++) begin
				rec_c.spd[cv*NSLOT+n+1] = (vlim_s2[cv] <= BAND_EDGE[n-1])
					? BAND_EDGE[n-1] : vlim_s2[cv];
				rec_c.mask[cv*NSLOT+n+1] = (vlim_s2[cv] <= BAND_EDGE[n-1]) || (n == 4)
					|| (vlim_s2[cv] < BAND_EDGE[n%4]);
			end
		end
	end

	bcm_rec_t           rec_s3;
	logic [6:0]         pct_s3;
	logic signed [29:0] us_s3 [2];

	always_ff @(posedge clk) begin
		if (rdy3) begin
			rec_s3 <= rec_c;
			pct_s3 <= pct_s2;
			for (int b = 0; b < 2; b++) begin
				us_s3[b] <= 30'(a10k_s2[b]) + 30'(blen_s2[b]) * 30'd100
					+ 30'(c_s2[b]) * 30'(lsq_s2[b]);
			end
		end
	end

	// ---------------- stage 4: scale and bias times ----------------
	logic [28:0] usc [2];
	bcm_rec_t    rec_s4;
	logic [35:0] y_s4 [4];

	// Clamp negative times to zero
	always_comb begin
		for (int b = 0; b < 2; b++) begin
			usc[b] = us_s3[b][29] ? '0 : us_s3[b][28:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			rec_s4  <= rec_s3;
			y_s4[0] <= 36'(usc[0]) * 36'(PCT_BASIC) + TIME_HALF;
			y_s4[1] <= 36'(usc[0]) * 36'(pct_s3) + TIME_HALF;
			y_s4[2] <= 36'(usc[1]) * 36'(PCT_BASIC) + TIME_HALF;
			y_s4[3] <= 36'(usc[1]) * 36'(pct_s3) + TIME_HALF;
		end
	end

	// ---------------- stage 5: reciprocal estimate ----------------
	bcm_rec_t    rec_s5;
	logic [35:0] y_s5 [4];
	logic [17:0] qe_s5 [4];
	logic [57:0] prod [4];

	always_comb begin
		for (int t = 0; t < 4; t++) begin
			prod[t] = 58'(y_s4[t]) * 58'(TIME_RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			rec_s5 <= rec_s4;
			for (int t = 0; t < 4; t++) begin
				y_s5[t]  <= y_s4[t];
				qe_s5[t] <= prod[t][57:40];
			end
		end
	end

	// ---------------- stage 6: correct and saturate ----------------
	bcm_rec_t    rec_s6;
	logic [14:0] tm_s6 [4];
	logic [36:0] rem [4];
	logic [17:0] qc [4];

	// Estimate is low by at most one
	always_comb begin
		for (int t = 0; t < 4; t++) begin
			rem[t] = 37'(y_s5[t]) - 37'(qe_s5[t]) * 37'(TIME_DIV);
			qc[t]  = qe_s5[t] + ((rem[t] >= 37'(TIME_DIV)) ? 18'd1 : 18'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy6) begin
			rec_s6 <= rec_s5;
			for (int t = 0; t < 4; t++) begin
				tm_s6[t] <= (qc[t] > 18'(TIME_MAX)) ? TIME_MAX : qc[t][14:0];
			end
		end
	end

	// ---------------- output sequencer ----------------
	logic              em_app_q;
	logic [11:0][11:0] em_spd_q;
	logic [11:0][15:0] em_dec_q;
	logic [14:0]       em_tm_q [4];
	logic [3:0]        pick;
	logic              load;

	assign load = v6_q && em_free;

	// Lowest pending slot goes out first
	always_comb begin
		pick = '0;
		for (int k = 11; k >= 0; k--) begin
			if (em_mask_q[k]) pick = 4'(k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_v_q    <= 1'b0;
			em_mask_q <= '0;
		end else if (load) begin
			em_v_q    <= 1'b1;
			em_mask_q <= rec_s6.app ? rec_s6.mask : 12'd1;
		end else if (em_v_q) begin
			em_v_q    <= (em_rest != '0);
			em_mask_q <= em_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			em_app_q <= rec_s6.app;
			em_spd_q <= rec_s6.spd;
			em_dec_q <= rec_s6.dec;
			for (int t = 0; t < 4; t++) begin
				em_tm_q[t] <= tm_s6[t];
			end
		end
	end

	// Register the result ports
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= em_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (em_v_q) begin
			applicable     <= em_app_q;
			curve_kind     <= em_app_q && (pick >= 4'(NSLOT));
			speed_from     <= em_app_q ? em_spd_q[pick] : '0;
			decel_value    <= em_app_q ? em_dec_q[pick] : '0;
			eb_time_basic  <= em_app_q ? em_tm_q[0] : '0;
			eb_time_scaled <= em_app_q ? em_tm_q[1] : '0;
			sb_time_basic  <= em_app_q ? em_tm_q[2] : '0;
			sb_time_scaled <= em_app_q ? em_tm_q[3] : '0;
			last_item      <= (em_rest == '0);
		end
	end

	// ---------------- assertions ----------------
	a_sequencer_pending: assert property (@(posedge clk) disable iff (!arst_n)
		em_v_q |-> (em_mask_q != '0))
		else $error("sequencer active with no pending slot");

	a_run_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last_item) |=> result_strobe)
		else $error("gap inside a result run");

	a_not_applicable_single: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !applicable) |-> last_item)
		else $error("rejected request produced more than one result");

	a_service_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && applicable && !curve_kind) |-> !last_item)
		else $error("run ended on the emergency curve");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> v1_q)
		else $error("accepted request not in first stage");

endmodule

`default_nettype wire

### tb/bcm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcm_checker: breakpoint run predictor and result comparator
// Watches the request and result channels of the brake conversion model,
// works out the expected breakpoint run of every accepted request and
// compares each strobed result field by field against the oldest expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_checker
	import bcm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [7:0]  brake_percent,
	input  wire logic [1:0]  position_kind,
	input  wire logic [11:0] train_length_m,
	input  wire logic [8:0]  max_speed_kmh,
	input  wire logic        result_strobe,
	input  wire logic        applicable,
	input  wire logic        curve_kind,
	input  wire logic [11:0] speed_from,
	input  wire logic [15:0] decel_value,
	input  wire logic [14:0] eb_time_basic,
	input  wire logic [14:0] eb_time_scaled,
	input  wire logic [14:0] sb_time_basic,
	input  wire logic [14:0] sb_time_scaled,
	input  wire logic        last_item,
	output int               fails,
	output int               pending,
	output int               checked,
	output int               inapplicable
);

	localparam logic       CURVE_EB  = 1'b0;
	localparam logic       CURVE_SB  = 1'b1;

	localparam longint unsigned EXP_2POW [16] = '{
		64'd23726566, 64'd19951585, 64'd18295684, 64'd17520007,
		64'd17144589, 64'd16959908, 64'd16868315, 64'd16822704,
		64'd16799944, 64'd16788576, 64'd16782895, 64'd16780055,
		64'd16778636, 64'd16777926, 64'd16777571, 64'd16777393
	};

	localparam longint BAND_POLY [5][4] = '{
		'{64'sd6630000000,  64'sd472000000, 64'sd6100000, -64'sd63000},
		'{64'sd13000000000, 64'sd514000000, -64'sd454000, 64'sd27300},
		'{64'sd4790000000,  64'sd581000000, -64'sd676000, 64'sd5580},
		'{64'sd4800000000,  64'sd552000000, -64'sd385000, 64'sd3000},
		'{64'sd5590000000,  64'sd506000000, 64'sd166000,  64'sd323}
	};

	localparam logic [11:0] STEP_SPEED [4] = '{12'd1600, 12'd1920, 12'd2400, 12'd2880};

	typedef struct {
		logic        app;
		logic        kind;
		logic [11:0] spd;
		logic [15:0] dec;
		logic [14:0] eb_b;
		logic [14:0] eb_s;
		logic [14:0] sb_b;
		logic [14:0] sb_s;
		logic        last;
	} breakpoint_t;

	breakpoint_t breakpoint_q[$];

	// Limit speed 16.85*lambda^0.428 in 1/16 km/h via log2 and 2^y
	function automatic logic [11:0] limit_speed(input logic [7:0] lam);
		longint unsigned msb, x, frac, lg, y, r;
		if (lam == 8'd0) begin
			return 12'd0;
		end
		msb = 0;
		for (int k = 1; k < 8; k++) begin
			if ((lam >> k) != 8'd0) begin
				msb = k;
			end
		end
		x = 64'(lam) << (24 - msb);
		frac = 0;
		for (int k = 0; k < 16; k++) begin
			x = (x * x) >> 24;
			frac = frac << 1;
			if (x >= (64'd1 << 25)) begin
				x = x >> 1;
				frac = frac | 64'd1;
			end
		end
		lg = (msb << 16) | frac;
		y = (lg * 64'd28049) >> 16;
		r = 64'd1 << 24;
		for (int k = 0; k < 16; k++) begin
			if (y[15-k]) begin
				r = (r * EXP_2POW[k]) >> 24;
			end
		end
		r = r << ((y >> 16) & 64'd7);
		r = (r * 64'd1104282 + (64'd1 << 35)) >> 36;
		return (r > 64'd4095) ? 12'd4095 : r[11:0];
	endfunction

	// Convert 1e-11 m/s2 to 1/4096 m/s2, round half up, clamp and saturate
	function automatic logic [15:0] decel_q12(input longint s);
		longint q;
		if (s <= 0) begin
			return 16'd0;
		end
		q = (s * 4096 + 64'sd50000000000) / 64'sd100000000000;
		return (q > 65535) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic logic [15:0] band_decel(input int n, input longint l);
		return decel_q12(BAND_POLY[n][0] + l * (BAND_POLY[n][1]
			+ l * (BAND_POLY[n][2] + l * BAND_POLY[n][3])));
	endfunction

	// Build-up time in microseconds, length in metres
	function automatic longint buildup_us(input longint a, input longint b,
			input longint c, input longint len);
		return a * 10000 + b * len * 100 + c * len * len;
	endfunction

	function automatic logic [14:0] time_q8(input longint us, input longint pct);
		longint q;
		if (us <= 0) begin
			return 15'd0;
		end
		q = (us * pct * 256 + 64'sd50000000) / 64'sd100000000;
		return (q > 32767) ? 15'h7FFF : q[14:0];
	endfunction

	// Append the breakpoints of one curve
	task automatic push_curve(input logic kind, input logic [7:0] lam,
			input breakpoint_t proto);
		breakpoint_t bp;
		logic [11:0] vl;
		longint l;
		vl = limit_speed(lam);
		l = longint'(lam);
		bp = proto;
		bp.kind = kind;
		bp.spd = 12'd0;
		bp.dec = decel_q12(64'sd750000000 * l + 64'sd7600000000);
		breakpoint_q.push_back(bp);
		if (vl < STEP_SPEED[0]) begin
			bp.spd = vl;
			bp.dec = band_decel(0, l);
			breakpoint_q.push_back(bp);
		end
		for (int n = 1; n <= 4; n++) begin
			if (vl <= STEP_SPEED[n-1]) begin
				bp.spd = STEP_SPEED[n-1];
				bp.dec = band_decel(n, l);
				breakpoint_q.push_back(bp);
			end else if (n == 4 || vl < STEP_SPEED[n]) begin
				bp.spd = vl;
				bp.dec = band_decel(n, l);
				breakpoint_q.push_back(bp);
			end
		end
	endtask

	// Predict the whole run of one request
	task automatic predict_run(input logic [7:0] lam, input logic [1:0] pos,
			input logic [11:0] len_m, input logic [8:0] vmax);
		breakpoint_t bp;
		longint len, fl, eb, sb, pct;
		logic [11:0] cap;
		len = longint'(len_m);
		fl = (len < 400) ? 400 : len;
		cap = (pos == POS_PASS_P) ? LEN_CAP_PASS : LEN_CAP_FRT;
		bp = '{default: '0};
		if (lam < LAM_LOW || lam > LAM_HIGH || vmax > SPEED_CAP || len_m >= cap) begin
			bp.last = 1'b1;
			breakpoint_q.push_back(bp);
			inapplicable++;
			return;
		end
		if (pos == POS_PASS_P) begin
			eb = buildup_us(230, 0, 17, fl);
			sb = buildup_us(300, 150, 10, len);
		end else if (pos == POS_FRT_P) begin
			eb = (len <= 900) ? buildup_us(230, 0, 17, fl) : buildup_us(-50, 160, 3, len);
			sb = (len <= 900) ? buildup_us(300, 277, 0, len) : buildup_us(1050, 32, 18, len);
		end else begin
			eb = (len <= 900) ? buildup_us(1200, 0, 5, len) : buildup_us(-40, 160, 3, len);
			sb = (len <= 900) ? buildup_us(300, 277, 0, fl) : buildup_us(1050, 32, 18, len);
		end
		pct = (pos >= POS_FRT_G) ? 116 : 120;
		bp.app = 1'b1;
		bp.eb_b = time_q8(eb, 100);
		bp.eb_s = time_q8(eb, pct);
		bp.sb_b = time_q8(sb, 100);
		bp.sb_s = time_q8(sb, pct);
		push_curve(CURVE_EB, lam, bp);
		push_curve(CURVE_SB, (lam > LAM_SB_CAP) ? LAM_SB_CAP : lam, bp);
		breakpoint_q[$].last = 1'b1;
	endtask

	task automatic cmp_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fails++;
		end
	endtask

	assign pending = breakpoint_q.size();

	// Predict on request accept, compare on result strobe
	always @(posedge clk) begin
		breakpoint_t e;
		if (!arst_n) begin
			fails = 0;
			checked = 0;
			inapplicable = 0;
		end else begin
			if (result_strobe) begin
				if (breakpoint_q.size() == 0) begin
					$error("unexpected result: speed_from %0d decel_value %0d",
						speed_from, decel_value);
					fails++;
				end else begin
					e = breakpoint_q.pop_front();
					checked++;
					cmp_field("applicable", e.app, applicable);
					cmp_field("curve_kind", e.kind, curve_kind);
					cmp_field("speed_from", e.spd, speed_from);
					cmp_field("decel_value", e.dec, decel_value);
					cmp_field("eb_time_basic", e.eb_b, eb_time_basic);
					cmp_field("eb_time_scaled", e.eb_s, eb_time_scaled);
					cmp_field("sb_time_basic", e.sb_b, sb_time_basic);
					cmp_field("sb_time_scaled", e.sb_s, sb_time_scaled);
					cmp_field("last_item", e.last, last_item);
				end
			end
			if (start && !busy) begin
				predict_run(brake_percent, position_kind, train_length_m, max_speed_kmh);
			end
		end
	end

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: brake conversion model testbench
// Drives train data requests (directed corner cases, then random mostly valid
// entries with random gaps) and lets the checker compare every breakpoint.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import bcm_pkg::*;

	localparam logic [1:0] POS_CODE3 = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  brake_percent;
	logic [1:0]  position_kind;
	logic [11:0] train_length_m;
	logic [8:0]  max_speed_kmh;
	logic        result_strobe, applicable, curve_kind, last_item;
	logic [11:0] speed_from;
	logic [15:0] decel_value;
	logic [14:0] eb_time_basic, eb_time_scaled, sb_time_basic, sb_time_scaled;
	int          fails, pending, checked, inapplicable;
	int          sent;

	brake_conversion_model uut (.*);

	bcm_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hold start until the request is taken
	task automatic send_request(input logic [7:0] lam, input logic [1:0] pos,
			input logic [11:0] len, input logic [8:0] vmax, input bit allow_gap);
		int gap;
		@(negedge clk);
		if (allow_gap && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			gap = $urandom_range(1, 9);
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		brake_percent <= lam;
		position_kind <= pos;
		train_length_m <= len;
		max_speed_kmh <= vmax;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	initial begin
		logic [11:0] cap;
		logic [1:0]  pos;
		start = 1'b0;
		brake_percent = '0;
		position_kind = '0;
		train_length_m = '0;
		max_speed_kmh = '0;
		sent = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: lambda, speed and length limits, every position code
		send_request(8'd0, POS_PASS_P, 12'd100, 9'd100, 1'b0);
		send_request(8'd29, POS_PASS_P, 12'd100, 9'd100, 1'b0);
		send_request(8'd30, POS_PASS_P, 12'd0, 9'd0, 1'b0);
		send_request(8'd250, POS_FRT_P, 12'd400, 9'd200, 1'b0);
		send_request(8'd251, POS_FRT_P, 12'd400, 9'd200, 1'b0);
		send_request(8'd255, POS_FRT_G, 12'hFFF, 9'h1FF, 1'b0);
		send_request(8'd100, POS_PASS_P, 12'd300, 9'd201, 1'b0);
		send_request(8'd100, POS_PASS_P, 12'd899, 9'd160, 1'b1);
		send_request(8'd100, POS_PASS_P, 12'd900, 9'd160, 1'b1);
		send_request(8'd135, POS_FRT_P, 12'd900, 9'd120, 1'b1);
		send_request(8'd136, POS_FRT_P, 12'd901, 9'd120, 1'b1);
		send_request(8'd150, POS_FRT_G, 12'd1499, 9'd100, 1'b1);
		send_request(8'd150, POS_FRT_G, 12'd1500, 9'd100, 1'b1);
		send_request(8'd80, POS_FRT_G, 12'd399, 9'd90, 1'b1);
		send_request(8'd80, POS_FRT_G, 12'd901, 9'd90, 1'b1);
		send_request(8'd200, POS_CODE3, 12'd700, 9'd180, 1'b1);
		send_request(8'd200, POS_CODE3, 12'd1200, 9'd180, 1'b1);
		send_request(8'd50, POS_PASS_P, 12'd0, 9'd200, 1'b1);
		send_request(8'd220, POS_PASS_P, 12'd500, 9'd511, 1'b1);

		// Random: mostly applicable entries, some noise, no gaps at the end
		for (int i = 0; i < 251; i++) begin
			if ($urandom_range(0, 4) != 0) begin
				pos = 2'($urandom_range(0, 3));
				cap = (pos == POS_PASS_P) ? LEN_CAP_PASS : LEN_CAP_FRT;
				send_request(8'($urandom_range(LAM_LOW, LAM_HIGH)), pos,
					12'($urandom_range(0, cap - 12'd1)),
					9'($urandom_range(0, SPEED_CAP)), i < 200);
			end else begin
				send_request(8'($urandom), 2'($urandom), 12'($urandom), 9'($urandom),
					i < 200);
			end
		end
		@(negedge clk);
		start <= 1'b0;

		wait (pending == 0);
		repeat (30) @(posedge clk);
		$display("%0d requests sent, %0d of them outside the model; %0d breakpoints checked",
			sent, inapplicable, checked);
		if (fails == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Hard stop on a hung run
	initial begin
		#5ms;
		$display("timeout with %0d results outstanding", pending);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
